/* hdl/rns_pkg.sv */
// Shared types and constants for the radius neighbour search block.
// Holds the request, result and point structs, the operation and result codes
// and the table size. Depends on nothing else.
package rns_pkg;

  // Table size and the cap on matches reported for one query.
  localparam int MaxPoints = 32;
  localparam int ResultCap = 32;
  localparam int CountW    = 6;
  localparam int IndexW    = 5;
  localparam int CoordW    = 16;
  localparam int LargestW  = 15;
  localparam int SquareW   = 32;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpQuery = 2'd1,
    OpAbove = 2'd2,
    OpNone  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KindAck   = 2'd0,
    KindMatch = 2'd1,
    KindNone  = 2'd2,
    KindFull  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StWait  = 4'b0100,
    StFlush = 4'b1000
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [CoordW-1:0]  x_coord;
    logic signed [CoordW-1:0]  y_coord;
    logic signed [CoordW-1:0]  z_coord;
    logic        [CoordW-1:0]  radius;
  } request_t;

  typedef struct packed {
    kind_t                     kind;
    logic [IndexW-1:0]         point_index;
    logic signed [CoordW-1:0]  point_x;
    logic signed [CoordW-1:0]  point_y;
    logic signed [CoordW-1:0]  point_z;
    logic [CountW-1:0]         stored_count;
    logic [LargestW-1:0]       largest_coord;
    logic                      last;
  } result_t;

  // One stored point as it travels along the chain of cells.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // The query as held for the whole scan.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     above;
    logic [SquareW-1:0]       r2;
  } query_t;

  // Outcome of the distance test for one stored point.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [IndexW-1:0] idx;
    point_t            pt;
  } dist_res_t;

endpackage

/* hdl/rns_cell.sv */
// One cell of the point chain: holds one stored point.
// It takes its neighbour's point whenever the chain moves. Depends on rns_pkg.
module rns_cell (
  input  logic            clk,
  input  logic            en,
  input  rns_pkg::point_t pt_in,
  output rns_pkg::point_t pt
);

  // The held point moves one place along the chain when enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      pt <= pt_in;
    end
  end

endmodule

/* hdl/rns_dist.sv */
// Distance test at the head of the chain: squares of the planar offsets are
// registered, then summed and compared with the squared radius.
// Depends on rns_pkg.
module rns_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  logic [rns_pkg::IndexW-1:0]    idx_in,
  input  rns_pkg::point_t               head,
  input  rns_pkg::query_t               query,
  output rns_pkg::dist_res_t            res
);

  logic signed [rns_pkg::CoordW:0]      dx;
  logic signed [rns_pkg::CoordW:0]      dy;
  logic signed [2*rns_pkg::CoordW+1:0]  dx_sq;
  logic signed [2*rns_pkg::CoordW+1:0]  dy_sq;
  logic                                 valid;
  logic                                 z_ok;
  logic [rns_pkg::SquareW-1:0]          sq_x;
  logic [rns_pkg::SquareW-1:0]          sq_y;
  logic [rns_pkg::IndexW-1:0]           idx;
  rns_pkg::point_t                      pt;
  logic [rns_pkg::SquareW:0]            sum;

  // Planar offsets and their squares; each square fits in 32 bits.
  assign dx    = (rns_pkg::CoordW+1)'(head.x) - (rns_pkg::CoordW+1)'(query.x);
  assign dy    = (rns_pkg::CoordW+1)'(head.y) - (rns_pkg::CoordW+1)'(query.y);
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  // Stage register after the multipliers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    sq_x <= dx_sq[rns_pkg::SquareW-1:0];
    sq_y <= dy_sq[rns_pkg::SquareW-1:0];
    z_ok <= !query.above || (head.z > query.z);
    idx  <= idx_in;
    pt   <= head;
  end

  // Sum and strict compare against the squared radius.
  assign sum = {1'b0, sq_x} + {1'b0, sq_y};

  always_comb begin
    res.valid = valid;
    res.hit   = valid && z_ok && (sum < {1'b0, query.r2});
    res.idx   = idx;
    res.pt    = pt;
  end

endmodule

/* hdl/radius_neighbor_search.sv */
// Radius neighbour search: top level with the chain of point cells, the
// distance test at its head and the result sequencing. Depends on rns_pkg,
// rns_cell and rns_dist.
// A load gives its single result in the cycle after the request.
// A query rotates the whole chain once, one cell per cycle, then passes
// through the wait and flush states to its final result, whatever the fill.
// Loads can be taken every cycle while idle; a new query only once idle again.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous reset empties the table and clears the largest coordinate.
module radius_neighbor_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rns_pkg::request_t request,
  output logic              strobe,
  output rns_pkg::result_t  result
);

  rns_pkg::state_t                state;
  logic [rns_pkg::CountW-1:0]     step;
  logic [rns_pkg::CountW-1:0]     count;
  logic [rns_pkg::LargestW-1:0]   max_coord;
  logic [rns_pkg::LargestW-1:0]   max_coord_next;
  rns_pkg::query_t                query;
  rns_pkg::point_t                held_pt;
  logic [rns_pkg::IndexW-1:0]     held_idx;
  logic                           have_held;
  logic [rns_pkg::CountW-1:0]     match_cnt;

  rns_pkg::point_t                cell_pt [rns_pkg::MaxPoints];
  rns_pkg::point_t                cell_in [rns_pkg::MaxPoints];
  rns_pkg::point_t                new_pt;
  rns_pkg::dist_res_t             dres;
  logic                           accept;
  logic                           do_load;
  logic                           table_full;
  logic                           chain_en;
  logic                           scan_valid;
  logic [rns_pkg::CountW-1:0]     scan_idx;
  logic                           take_hit;

  assign busy       = (state != rns_pkg::StIdle);
  assign accept     = start && !busy;
  assign table_full = (count >= rns_pkg::CountW'(rns_pkg::MaxPoints));
  assign do_load    = accept && (request.op == rns_pkg::OpLoad) && !table_full;
  assign chain_en   = do_load || (state == rns_pkg::StScan);

  assign new_pt.x = request.x_coord;
  assign new_pt.y = request.y_coord;
  assign new_pt.z = request.z_coord;

  // On load the chain shifts away from the head to take in the new point.
  // During a scan it rotates towards the head, so the head sees the points
  // newest first and the chain is back in place after one full turn.
  always_comb begin
    if (do_load) begin
      cell_in[0] = new_pt;
      for (int i = 1; i < rns_pkg::MaxPoints; i++) begin
        cell_in[i] = cell_pt[i-1];
      end
    end else begin
      cell_in[rns_pkg::MaxPoints-1] = cell_pt[0];
      for (int i = 0; i < rns_pkg::MaxPoints - 1; i++) begin
        cell_in[i] = cell_pt[i+1];
      end
    end
  end

  for (genvar g = 0; g < rns_pkg::MaxPoints; g++) begin : g_cell
    rns_cell u_cell (
      .clk   (clk),
      .en    (chain_en),
      .pt_in (cell_in[g]),
      .pt    (cell_pt[g])
    );
  end

  // The head cell holds the point that was step places from the newest.
  assign scan_valid = (state == rns_pkg::StScan) && (step < count);
  assign scan_idx   = count - 1'b1 - step;

  rns_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .valid_in (scan_valid),
    .idx_in   (scan_idx[rns_pkg::IndexW-1:0]),
    .head     (cell_pt[0]),
    .query    (query),
    .res      (dres)
  );

  assign take_hit = dres.hit && (match_cnt < rns_pkg::CountW'(rns_pkg::ResultCap));

  // Largest positive x or y seen on load.
  always_comb begin
    max_coord_next = max_coord;
    if (!request.x_coord[rns_pkg::CoordW-1] &&
        request.x_coord[rns_pkg::LargestW-1:0] > max_coord_next) begin
      max_coord_next = request.x_coord[rns_pkg::LargestW-1:0];
    end
    if (!request.y_coord[rns_pkg::CoordW-1] &&
        request.y_coord[rns_pkg::LargestW-1:0] > max_coord_next) begin
      max_coord_next = request.y_coord[rns_pkg::LargestW-1:0];
    end
  end

  // Control state: sequencer, step counter, table fill and held match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rns_pkg::StIdle;
      step      <= '0;
      count     <= '0;
      max_coord <= '0;
      have_held <= 1'b0;
      match_cnt <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        rns_pkg::StIdle: begin
          if (accept) begin
            if (request.op == rns_pkg::OpLoad) begin
              strobe <= 1'b1;
              if (!table_full) begin
                count     <= count + 1'b1;
                max_coord <= max_coord_next;
              end
            end else if (request.op == rns_pkg::OpQuery ||
                         request.op == rns_pkg::OpAbove) begin
              state     <= rns_pkg::StScan;
              step      <= '0;
              have_held <= 1'b0;
              match_cnt <= '0;
            end
          end
        end
        rns_pkg::StScan: begin
          step <= step + 1'b1;
          if (step == rns_pkg::CountW'(rns_pkg::MaxPoints - 1)) begin
            state <= rns_pkg::StWait;
          end
        end
        rns_pkg::StWait: begin
          state <= rns_pkg::StFlush;
        end
        rns_pkg::StFlush: begin
          strobe <= 1'b1;
          state  <= rns_pkg::StIdle;
        end
        default: begin
          state <= rns_pkg::StIdle;
        end
      endcase
      // A new match releases the previously held one, which is not the last.
      if (take_hit) begin
        have_held <= 1'b1;
        match_cnt <= match_cnt + 1'b1;
        if (have_held) begin
          strobe <= 1'b1;
        end
      end
    end
  end

  // Query registers, taken when a query request is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      query.x     <= request.x_coord;
      query.y     <= request.y_coord;
      query.z     <= request.z_coord;
      query.above <= (request.op == rns_pkg::OpAbove);
      query.r2    <= request.radius * request.radius;
    end
  end

  // Result payload and the held match.
  always_ff @(posedge clk) begin
    if (take_hit) begin
      held_pt  <= dres.pt;
      held_idx <= dres.idx;
    end
    result.stored_count  <= count;
    result.largest_coord <= max_coord;
    result.last          <= 1'b1;
    if (state == rns_pkg::StIdle) begin
      if (table_full) begin
        result.kind         <= rns_pkg::KindFull;
        result.point_index  <= '0;
        result.point_x      <= '0;
        result.point_y      <= '0;
        result.point_z      <= '0;
      end else begin
        result.kind          <= rns_pkg::KindAck;
        result.point_index   <= count[rns_pkg::IndexW-1:0];
        result.point_x       <= request.x_coord;
        result.point_y       <= request.y_coord;
        result.point_z       <= request.z_coord;
        result.stored_count  <= count + 1'b1;
        result.largest_coord <= max_coord_next;
      end
    end else if (state == rns_pkg::StFlush && !have_held) begin
      result.kind        <= rns_pkg::KindNone;
      result.point_index <= '0;
      result.point_x     <= '0;
      result.point_y     <= '0;
      result.point_z     <= '0;
    end else begin
      result.kind        <= rns_pkg::KindMatch;
      result.point_index <= held_idx;
      result.point_x     <= held_pt.x;
      result.point_y     <= held_pt.y;
      result.point_z     <= held_pt.z;
      result.last        <= (state == rns_pkg::StFlush);
    end
  end

endmodule

/* hdl/rns_checker.sv */
// Port-level checks for the radius neighbour search block, with the bind
// that attaches them to the top level. Depends on rns_pkg and
// radius_neighbor_search.
module rns_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input rns_pkg::request_t request,
  input logic              strobe,
  input rns_pkg::result_t  result
);

  // A load request gives exactly one final result in the next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.op == rns_pkg::OpLoad |=> strobe && result.last)
    else $error("load request without a result in the next cycle");

  // A query request keeps the block busy while it scans.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.op == rns_pkg::OpQuery || request.op == rns_pkg::OpAbove)
    |=> busy)
    else $error("query request did not make the block busy");

  // More results of the same request only come while the block is busy.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("non-final result while the block is idle");

  // Single-result kinds always close their request.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.kind == rns_pkg::KindNone || result.kind == rns_pkg::KindFull ||
               result.kind == rns_pkg::KindAck) |-> result.last)
    else $error("acknowledge, full or no-match result not marked last");

  // An acknowledged load always leaves at least one point stored.
  a_ack_count: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == rns_pkg::KindAck |-> result.stored_count != '0)
    else $error("acknowledged load with an empty table");

endmodule

bind radius_neighbor_search rns_checker u_rns_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe),
  .result  (result)
);

/* bench/testbench.sv */
// Self-checking bench for radius_neighbor_search: loads points, runs standard and
// from-above radius queries, and checks every strobed result against a predictor.
// Depends on rns_pkg and the radius_neighbor_search RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rns_pkg::*;

  localparam int RandomItems = 430;
  localparam int CalmTail    = 60;
  localparam int DrainCycles = MaxPoints + 10;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     strobe;
  result_t  result;

  radius_neighbor_search dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
  );

  // Keeps a shadow copy of the point table, works out the results that each
  // accepted request should give and compares them with what comes out.
  class search_scoreboard;
    result_t                  pending_results[$];
    logic signed [CoordW-1:0] tab_x[MaxPoints];
    logic signed [CoordW-1:0] tab_y[MaxPoints];
    logic signed [CoordW-1:0] tab_z[MaxPoints];
    int count_held;
    int largest_held;
    int errors;
    int checked;
    int loads_acked;
    int loads_refused;
    int queries_seen;
    int matches_due;
    int empty_queries;

    function new();
      count_held    = 0;
      largest_held  = 0;
      errors        = 0;
      checked       = 0;
      loads_acked   = 0;
      loads_refused = 0;
      queries_seen  = 0;
      matches_due   = 0;
      empty_queries = 0;
    endfunction

    // A result with the point fields cleared and the table status filled in.
    function result_t status_result(kind_t k);
      result_t r;
      r               = '0;
      r.kind          = k;
      r.stored_count  = count_held[CountW-1:0];
      r.largest_coord = largest_held[LargestW-1:0];
      return r;
    endfunction

    function void note_request(request_t req);
      result_t r;
      result_t hits[$];
      int      qx;
      int      qy;
      int      qz;
      int      k;
      longint  dx;
      longint  dy;
      longint  rsq;
      qx  = int'(req.x_coord);
      qy  = int'(req.y_coord);
      qz  = int'(req.z_coord);
      rsq = longint'(req.radius) * longint'(req.radius);
      case (req.op)
        OpLoad: begin
          if (count_held >= MaxPoints) begin
            // Table full: nothing is stored and the point fields read zero.
            r      = status_result(KindFull);
            r.last = 1'b1;
            pending_results.push_back(r);
            loads_refused++;
          end else begin
            tab_x[count_held] = req.x_coord;
            tab_y[count_held] = req.y_coord;
            tab_z[count_held] = req.z_coord;
            // The largest coordinate only ever grows, and never below zero.
            if (qx > largest_held) largest_held = qx;
            if (qy > largest_held) largest_held = qy;
            count_held++;
            r             = status_result(KindAck);
            k             = count_held - 1;
            r.point_index = k[IndexW-1:0];
            r.point_x     = req.x_coord;
            r.point_y     = req.y_coord;
            r.point_z     = req.z_coord;
            r.last        = 1'b1;
            pending_results.push_back(r);
            loads_acked++;
          end
        end
        OpQuery, OpAbove: begin
          queries_seen++;
          // Newest point first; strict compare on the squared planar distance.
          for (k = count_held - 1; k >= 0 && hits.size() < ResultCap; k--) begin
            if (req.op == OpAbove && !(int'(tab_z[k]) > qz)) continue;
            dx = longint'(tab_x[k]) - qx;
            dy = longint'(tab_y[k]) - qy;
            if (dx * dx + dy * dy < rsq) begin
              r             = status_result(KindMatch);
              r.point_index = k[IndexW-1:0];
              r.point_x     = tab_x[k];
              r.point_y     = tab_y[k];
              r.point_z     = tab_z[k];
              hits.push_back(r);
            end
          end
          if (hits.size() == 0) begin
            r      = status_result(KindNone);
            r.last = 1'b1;
            pending_results.push_back(r);
            empty_queries++;
          end else begin
            foreach (hits[i]) begin
              r      = hits[i];
              r.last = (i == hits.size() - 1);
              pending_results.push_back(r);
            end
            matches_due += hits.size();
          end
        end
        default: begin
          // The unused operation leaves the block untouched.
        end
      endcase
    endfunction

    task report(string what, int got_v, int want_v);
      errors++;
      if (errors <= 50)
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got_v,
                 want_v);
    endtask

    task check_result(result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding, kind", int'(got.kind), -1);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) report("kind", int'(got.kind), int'(want.kind));
      if (got.point_index !== want.point_index)
        report("point_index", int'(got.point_index), int'(want.point_index));
      if (got.point_x !== want.point_x)
        report("point_x", int'(got.point_x), int'(want.point_x));
      if (got.point_y !== want.point_y)
        report("point_y", int'(got.point_y), int'(want.point_y));
      if (got.point_z !== want.point_z)
        report("point_z", int'(got.point_z), int'(want.point_z));
      if (got.stored_count !== want.stored_count)
        report("stored_count", int'(got.stored_count), int'(want.stored_count));
      if (got.largest_coord !== want.largest_coord)
        report("largest_coord", int'(got.largest_coord), int'(want.largest_coord));
      if (got.last !== want.last) report("last", int'(got.last), int'(want.last));
    endtask
  endclass

  search_scoreboard sb = new();

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Results are taken as they stand just before each rising edge.
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(result);
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_coord();
    logic [CoordW-1:0] raw;
    raw = CoordW'($urandom());
    return int'($signed(raw));
  endfunction

  function automatic int near(int centre, int span);
    int off;
    off = $urandom_range(0, 2 * span);
    return clamp16(centre + off - span);
  endfunction

  function automatic request_t make_req(op_t op, int x, int y, int z, int r);
    request_t q;
    q.op      = op;
    q.x_coord = x[CoordW-1:0];
    q.y_coord = y[CoordW-1:0];
    q.z_coord = z[CoordW-1:0];
    q.radius  = r[CoordW-1:0];
    return q;
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_request(request_t req);
    @(negedge clk);
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  // Drops start for a number of cycles with noise on the request bus.
  task automatic hold_off(int cycles);
    @(negedge clk);
    start   = 1'b0;
    request = request_t'({$urandom(), $urandom(), $urandom()});
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Timeout guard.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding", sb.pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus.
  initial begin
    int   sent;
    int   idle_pct;
    int   pick;
    int   k;
    int   cx;
    int   cy;
    int   cz;
    int   qx;
    int   qy;
    int   qz;
    int   rad;
    op_t  qop;

    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty table, equal-distance boundary, zero radius,
    // extreme coordinates, from-above filtering and the unused operation.
    send_request(make_req(OpQuery, 0, 0, 0, 65535));
    send_request(make_req(OpAbove, 0, 0, 0, 65535));
    send_request(make_req(OpNone, -1, -1, -1, 65535));
    send_request(make_req(OpLoad, -5, -7, 9, 0));
    send_request(make_req(OpLoad, 3, 4, 0, 65535));
    send_request(make_req(OpQuery, 0, 0, 0, 5));
    send_request(make_req(OpQuery, 0, 0, 0, 6));
    send_request(make_req(OpQuery, 3, 4, 0, 0));
    send_request(make_req(OpLoad, 32767, -32768, 32767, 0));
    send_request(make_req(OpLoad, -32768, 32767, -32768, 0));
    send_request(make_req(OpLoad, -1, -1, -1, 0));
    send_request(make_req(OpLoad, -32768, -32768, 0, 0));
    send_request(make_req(OpQuery, 0, 0, 0, 65535));
    send_request(make_req(OpQuery, 32767, 32767, 0, 65535));
    send_request(make_req(OpAbove, 0, 0, 0, 65535));
    send_request(make_req(OpAbove, 0, 0, -32768, 65535));
    send_request(make_req(OpAbove, 0, 0, 32767, 65535));
    hold_off(3);
    send_request(make_req(OpQuery, -32768, 32767, 0, 1));
    send_request(make_req(OpQuery, 0, 0, 0, 32768));
    send_request(make_req(OpNone, 0, 0, 0, 0));
    send_request(make_req(OpAbove, -32768, -32768, -1, 65535));

    // Random part: clustered points so that queries find several neighbours,
    // with a share of wide-range points, queries and radii.
    sent     = 0;
    idle_pct = 0;
    cx       = 0;
    cy       = 0;
    cz       = 0;
    while (sent < RandomItems) begin
      if (sent % 40 == 0) begin
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        cx       = $urandom_range(0, 60000) - 30000;
        cy       = $urandom_range(0, 60000) - 30000;
        cz       = $urandom_range(0, 60000) - 30000;
      end
      if (sent >= RandomItems - CalmTail) idle_pct = 0;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_request(make_req(OpNone, rand_coord(), rand_coord(), rand_coord(),
                              $urandom_range(0, 65535)));
      end else begin
        if ((sb.count_held < MaxPoints && pick < 45) || pick < 12) begin
          if ($urandom_range(0, 4) == 0)
            send_request(make_req(OpLoad, rand_coord(), rand_coord(), rand_coord(),
                                  $urandom_range(0, 65535)));
          else
            send_request(make_req(OpLoad, near(cx, 1500), near(cy, 1500), near(cz, 1500),
                                  $urandom_range(0, 65535)));
        end else begin
          qop = ($urandom_range(0, 1) == 0) ? OpQuery : OpAbove;
          if (sb.count_held > 0 && $urandom_range(0, 3) != 0) begin
            k  = $urandom_range(0, sb.count_held - 1);
            qx = near(int'(sb.tab_x[k]), 500);
            qy = near(int'(sb.tab_y[k]), 500);
            qz = near(int'(sb.tab_z[k]), 300);
          end else begin
            qx = rand_coord();
            qy = rand_coord();
            qz = rand_coord();
          end
          case ($urandom_range(0, 9))
            0:       rad = 0;
            1:       rad = 65535;
            2, 3:    rad = $urandom_range(0, 65535);
            4, 5, 6: rad = $urandom_range(0, 400);
            default: rad = $urandom_range(0, 4000);
          endcase
          send_request(make_req(qop, qx, qy, qz, rad));
        end
        sent++;
      end
      if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 11));
    end

    // Drain: wait for every expected result, then watch for strays.
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d stored points, %0d loads refused on a full table and %0d queries.",
             sb.loads_acked, sb.loads_refused, sb.queries_seen);
    $display("Queries gave %0d neighbours and %0d empty answers; %0d results compared.",
             sb.matches_due, sb.empty_queries, sb.checked);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rns_pkg.sv
hdl/rns_cell.sv
hdl/rns_dist.sv
hdl/radius_neighbor_search.sv
hdl/rns_checker.sv
bench/testbench.sv
